>>> design/tsgp_pkg.sv
package tsgp_pkg;
  localparam int unsigned MaxDimDefault = 4096;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;
  localparam logic [CfgIdxW-1:0] RegOrientation = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWidth = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHeight = 3'd2;
  localparam logic [CfgIdxW-1:0] RegColorStart = 3'd3;
  localparam logic [CfgIdxW-1:0] RegColorMid = 3'd4;
  localparam logic [CfgIdxW-1:0] RegColorEnd = 3'd5;
  localparam logic [7:0] AlphaOpaque = 8'hff;
endpackage

>>> design/tsgp_div.sv
// Pipelined restoring divider: one quotient bit per stage, magnitude only.
// Stage count = NW; numerator NW bits, denominator DW bits (den > 0).
module tsgp_div #(
  parameter int unsigned NW = 21,
  parameter int unsigned DW = 14,
  parameter int unsigned TW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_vld,
  output logic [NW-1:0] out_quo,
  output logic          out_rem_nz,
  output logic [TW-1:0] out_tag
);
  logic          vld_r [NW+1];
  logic [NW-1:0] num_r [NW+1];
  logic [DW-1:0] rem_r [NW+1];
  logic [DW-1:0] den_r [NW+1];
  logic [TW-1:0] tag_r [NW+1];

  always_comb begin
    vld_r[0] = in_vld;
    num_r[0] = in_num;
    rem_r[0] = '0;
    den_r[0] = in_den;
    tag_r[0] = in_tag;
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;
    always_comb begin
      trial = {rem_r[s], num_r[s][NW-1]};
      ge = trial >= {1'b0, den_r[s]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      num_r[s+1] <= {num_r[s][NW-2:0], ge};
      rem_r[s+1] <= ge ? DW'(trial - {1'b0, den_r[s]}) : DW'(trial);
      den_r[s+1] <= den_r[s];
      tag_r[s+1] <= tag_r[s];
    end
  end

  assign out_vld = vld_r[NW];
  assign out_quo = num_r[NW];
  assign out_rem_nz = rem_r[NW] != '0;
  assign out_tag = tag_r[NW];
endmodule

>>> design/tsgp_chan.sv
// One colour channel: a + floor(d * num / den), saturated to 0..255.
// Registered steps in order: multiply, divide pipeline, combine.
module tsgp_chan #(
  parameter int unsigned PW = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [7:0]    in_a,
  input  logic [7:0]    in_b,
  input  logic [PW-1:0] in_num,
  input  logic [PW-1:0] in_den,
  input  logic          in_mid_only,
  output logic [7:0]    out_ch
);
  localparam int unsigned NW = PW + 8;
  localparam int unsigned TW = 10;

  logic          vld_r;
  logic [NW-1:0] mag_r;
  logic          neg_r;
  logic [PW-1:0] den_r;
  logic [7:0]    a_r;
  logic          mo_r;
  logic [8:0]    diff;
  logic [7:0]    dmag;

  // stage 1: |b - a| * num
  always_comb begin
    diff = {1'b0, in_b} - {1'b0, in_a};
    dmag = diff[8] ? 8'(-diff) : diff[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    mag_r <= NW'(dmag) * NW'(in_num);
    neg_r <= diff[8];
    den_r <= in_mid_only ? PW'(1) : in_den;
    // mid only: a is the mid colour here, so a + 0 gives it
    a_r   <= in_a;
    mo_r  <= in_mid_only;
  end

  logic          dv;
  logic [NW-1:0] quo;
  logic          rnz;
  logic [TW-1:0] tag;

  tsgp_div #(.NW(NW), .DW(PW), .TW(TW)) u_div (
    .clk(clk), .rst_n(rst_n),
    .in_vld(vld_r), .in_num(mo_r ? '0 : mag_r), .in_den(den_r),
    .in_tag({neg_r, mo_r, a_r}),
    .out_vld(dv), .out_quo(quo), .out_rem_nz(rnz), .out_tag(tag)
  );

  // combine: floor for negative, then saturate
  logic [NW+1:0] q_s;
  logic [NW+1:0] v_s;
  logic [7:0]    ch_r;
  always_comb begin
    q_s = {2'b00, quo};
    if (tag[9]) begin
      q_s = (NW+2)'(-q_s) - (NW+2)'(rnz);
    end
    v_s = q_s + (NW+2)'(tag[7:0]);
  end

  always_ff @(posedge clk) begin
    if (v_s[NW+1]) begin
      ch_r <= 8'd0;
    end else if (v_s[NW:8] != '0) begin
      ch_r <= 8'hff;
    end else begin
      ch_r <= v_s[7:0];
    end
  end

  assign out_ch = ch_r;
  // dv marks result validity; tracked by the top-level valid line
  logic unused_dv;
  assign unused_dv = dv;
endmodule

>>> design/three_stop_gradient_pixel.sv
// Three-stop gradient pixel generator. One request is taken in every cycle
// (busy is always low); its result reaches out_valid through the stage A
// register, the channel multiply register, the bit-serial divider pipeline
// (one quotient bit per stage) and the channel combine register. PW is the
// width needed for MAX_DIM and at least 13; the divider depth grows with it.
// Results cannot be stalled. Configuration must be written only while
// no request is in flight.
module three_stop_gradient_pixel #(
  parameter int unsigned MAX_DIM = tsgp_pkg::MaxDimDefault
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [11:0]                         in_line_index,
  input  logic [11:0]                         in_position,
  input  logic [12:0]                         in_split_point,
  input  logic                                cfg_we,
  input  logic [tsgp_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [tsgp_pkg::CfgDataW-1:0]       cfg_data,
  output logic                                out_valid,
  output logic [23:0]                         out_pixel_address,
  output logic [31:0]                         out_pixel_argb
);
  import tsgp_pkg::*;

  localparam int unsigned PW = $clog2(MAX_DIM + 1) > 13 ? $clog2(MAX_DIM + 1) : 13;
  localparam int unsigned LAT = PW + 8 + 3;

  // configuration registers
  logic        orient_r;
  logic [12:0] width_r, height_r;
  logic [23:0] cs_r, cm_r, ce_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r <= 1'b0;
      width_r  <= 13'd256;
      height_r <= 13'd256;
      cs_r <= '0;
      cm_r <= '0;
      ce_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegOrientation: orient_r <= cfg_data[0];
        RegWidth:       width_r  <= cfg_data[12:0];
        RegHeight:      height_r <= cfg_data[12:0];
        RegColorStart:  cs_r <= cfg_data;
        RegColorMid:    cm_r <= cfg_data;
        RegColorEnd:    ce_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  function automatic logic [PW-1:0] clamp_dim(input logic [12:0] d);
    logic [PW-1:0] dx;
    dx = PW'(d);
    if (dx == '0) return PW'(1);
    if (dx > PW'(MAX_DIM)) return PW'(MAX_DIM);
    return dx;
  endfunction

  // stage A: clamp dims and split, pick segment
  logic          a_vld_r;
  logic          a_seg2_r, a_mid_r;
  logic [PW-1:0] a_num_r, a_den_r;
  logic [11:0]   a_mul_r, a_add_r;
  logic [PW-1:0] a_w_r;
  logic [PW-1:0] w_c, h_c, len_c, spl_c;

  always_comb begin
    w_c = clamp_dim(width_r);
    h_c = clamp_dim(height_r);
    len_c = orient_r ? h_c : w_c;
    spl_c = (PW'(in_split_point) > len_c) ? len_c : PW'(in_split_point);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start;
    end
    a_seg2_r <= !(PW'(in_position) < spl_c);
    a_mid_r  <= !(PW'(in_position) < spl_c) && (len_c == spl_c);
    a_num_r  <= (PW'(in_position) < spl_c) ? PW'(in_position)
                                          : PW'(in_position) - spl_c;
    a_den_r  <= (PW'(in_position) < spl_c) ? spl_c : len_c - spl_c;
    a_mul_r  <= orient_r ? in_position : in_line_index;
    a_add_r  <= orient_r ? in_line_index : in_position;
    a_w_r    <= w_c;
  end

  // channels
  logic [23:0] ca, cb;
  logic [7:0]  ch [3];
  assign ca = a_seg2_r ? cm_r : cs_r;
  assign cb = a_seg2_r ? ce_r : cm_r;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    tsgp_chan #(.PW(PW)) u_ch (
      .clk(clk), .rst_n(rst_n), .in_vld(a_vld_r),
      .in_a(ca[8*c +: 8]), .in_b(cb[8*c +: 8]),
      .in_num(a_num_r), .in_den(a_den_r), .in_mid_only(a_mid_r),
      .out_ch(ch[c])
    );
  end

  // address path: multiply, then delay to match the colour pipe
  logic [23:0] addr_r [LAT];
  logic        vld_r  [LAT];
  always_ff @(posedge clk) begin
    addr_r[0] <= 24'((36'(a_mul_r) * 36'(a_w_r)) + 36'(a_add_r));
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= a_vld_r;
    end
  end
  for (genvar i = 1; i < LAT; i++) begin : g_dly
    always_ff @(posedge clk) begin
      addr_r[i] <= addr_r[i-1];
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign out_valid = vld_r[PW+9];
  assign out_pixel_address = addr_r[PW+9];
  assign out_pixel_argb = {AlphaOpaque, ch[2], ch[1], ch[0]};

  logic unused_tail;
  assign unused_tail = ^{vld_r[LAT-1], addr_r[LAT-1]};
endmodule
